FILE: src/vvm_pkg.sv
// ----------------------------------------------------------------------------
// vvm_pkg
// Shared types and codes for the version vector merge block.
// ----------------------------------------------------------------------------
package vvm_pkg;

  // Request kinds
  localparam logic KIND_MERGE  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;  // write zero at the sweep address, advance the sweep
    logic load;   // capture the request, issue the table read
    logic exec;   // apply read-modify-write, register the result
  } vvm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // sweep is on its final entry
  } vvm_stat_t;

endpackage

FILE: src/vvm_ctrl.sv
// ----------------------------------------------------------------------------
// vvm_ctrl
// Sequencer: clearing sweep after reset, then load and execute per request.
// ----------------------------------------------------------------------------
module vvm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  vvm_pkg::vvm_stat_t stat_i,
  output vvm_pkg::vvm_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      busy_q  <= 1'b1;
    end else begin
      unique case (state_q)
        StClear: begin
          if (stat_i.clear_last) begin
            state_q <= StIdle;
            busy_q  <= 1'b0;
          end
        end
        StIdle: begin
          if (start_i) begin
            state_q <= StExec;
            busy_q  <= 1'b1;
          end
        end
        StExec: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= StClear;
          busy_q  <= 1'b1;
        end
      endcase
    end
  end

  assign busy_o      = busy_q;
  assign cmd_o.clear = (state_q == StClear);
  assign cmd_o.load  = (state_q == StIdle) && start_i;
  assign cmd_o.exec  = (state_q == StExec);

endmodule

FILE: src/vvm_dpath.sv
// ----------------------------------------------------------------------------
// vvm_dpath
// Sequence table, counters and result registers.
// ----------------------------------------------------------------------------
module vvm_dpath #(
  parameter int NODE_COUNT = 64,
  parameter int SEQ_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vvm_pkg::vvm_cmd_t  cmd_i,
  output vvm_pkg::vvm_stat_t stat_o,
  input  logic               cfg_valid_i,
  input  logic [5:0]         cfg_own_node_i,
  input  logic               kind_i,
  input  logic [5:0]         node_index_i,
  input  logic               use_own_node_i,
  input  logic [31:0]        entry_seq_i,
  input  logic               last_entry_i,
  output logic               result_valid_o,
  output logic               missing_valid_o,
  output logic [5:0]         missing_node_o,
  output logic [31:0]        first_missing_o,
  output logic [31:0]        last_missing_o,
  output logic               vector_done_o,
  output logic               local_has_newer_o,
  output logic               remote_had_newer_o,
  output logic               announce_o
);

  localparam int IdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int ExtW = (IdxW + 1 > 7) ? IdxW + 1 : 7;
  localparam int CntW = $clog2(NODE_COUNT + 1);

  logic [SEQ_BITS-1:0] seq_mem_q [NODE_COUNT];
  logic [SEQ_BITS-1:0] rd_q;

  logic [IdxW-1:0]     clr_addr_q;
  logic [5:0]          own_node_q;

  // Captured request
  logic                kind_q;
  logic [5:0]          node_q;
  logic [IdxW-1:0]     idx_q;
  logic                inrange_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic                last_q;

  logic [CntW-1:0]     nz_q, nz_d;
  logic [CntW-1:0]     pnz_q, pnz_d;
  logic                lns_q, lns_d;
  logic                rns_q, rns_d;

  logic [5:0]          target;
  logic [ExtW-1:0]     target_ext;
  logic [IdxW-1:0]     ld_idx;

  logic                wr_en;
  logic [SEQ_BITS-1:0] new_cur;
  logic [SEQ_BITS-1:0] cur_inc;
  logic                miss;
  logic                done;
  logic                lhn;
  logic                ann;

  // Target node of the request being loaded
  assign target     = (kind_i == vvm_pkg::KIND_UPDATE && use_own_node_i) ? own_node_q
                                                                          : node_index_i;
  assign target_ext = ExtW'(target);
  assign ld_idx     = target_ext[IdxW-1:0];

  assign stat_o.clear_last = (clr_addr_q == IdxW'(NODE_COUNT - 1));

  // Table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      seq_mem_q[clr_addr_q] <= '0;
    end else if (wr_en) begin
      seq_mem_q[idx_q] <= seq_q;
    end
    if (cmd_i.load) begin
      rd_q <= seq_mem_q[ld_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      own_node_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + IdxW'(1);
      end
      if (cfg_valid_i) begin
        own_node_q <= cfg_own_node_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      node_q    <= target;
      idx_q     <= ld_idx;
      inrange_q <= (target_ext < ExtW'(NODE_COUNT));
      seq_q     <= SEQ_BITS'(entry_seq_i);
      last_q    <= last_entry_i;
    end
  end

  assign cur_inc = rd_q + SEQ_BITS'(1);

  always_comb begin
    wr_en   = 1'b0;
    new_cur = rd_q;
    miss    = 1'b0;
    done    = 1'b0;
    lhn     = 1'b0;
    ann     = 1'b0;
    nz_d    = nz_q;
    pnz_d   = pnz_q;
    lns_d   = lns_q;
    rns_d   = rns_q;
    if (kind_q == vvm_pkg::KIND_UPDATE) begin
      if (inrange_q) begin
        wr_en = cmd_i.exec;
        if (rd_q == '0 && seq_q != '0) begin
          nz_d = nz_q + CntW'(1);
        end else if (rd_q != '0 && seq_q == '0 && nz_q != '0) begin
          nz_d = nz_q - CntW'(1);
        end
        ann = (seq_q > rd_q);
      end
    end else begin
      if (inrange_q) begin
        if (rd_q < seq_q) begin
          rns_d   = 1'b1;
          miss    = 1'b1;
          wr_en   = cmd_i.exec;
          new_cur = seq_q;
          if (rd_q == '0) begin
            nz_d = nz_q + CntW'(1);
          end
        end else if (rd_q > seq_q) begin
          lns_d = 1'b1;
        end
        if (new_cur != '0 && pnz_q < CntW'(NODE_COUNT)) begin
          pnz_d = pnz_q + CntW'(1);
        end
      end
      if (last_q) begin
        done  = 1'b1;
        lhn   = lns_d || (nz_d > pnz_d);
        lns_d = 1'b0;
        rns_d = 1'b0;
        pnz_d = '0;
      end
    end
  end

  // Merge state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q           <= '0;
      pnz_q          <= '0;
      lns_q          <= 1'b0;
      rns_q          <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.exec;
      if (cmd_i.exec) begin
        nz_q  <= nz_d;
        pnz_q <= pnz_d;
        lns_q <= lns_d;
        rns_q <= rns_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      missing_valid_o    <= miss;
      missing_node_o     <= miss ? node_q : 6'd0;
      first_missing_o    <= miss ? 32'(cur_inc) : 32'd0;
      last_missing_o     <= miss ? 32'(seq_q) : 32'd0;
      vector_done_o      <= done;
      local_has_newer_o  <= lhn;
      remote_had_newer_o <= done && (rns_q || miss);
      announce_o         <= ann;
    end
  end

endmodule

FILE: src/version_vector_merge.sv
// ----------------------------------------------------------------------------
// version_vector_merge
// Local version vector with merge of received entries and local updates.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   payload
//  --------  ---------  --------------------------  ---------------------------
//  request   in         start high, busy low        kind, node, seq, flags
//  result    out        result_valid_o, one cycle   missing range, verdicts
//  config    in         cfg_valid_i & cfg_ready_o   own node index
//
// On acceptance the table read is issued; the execute state then does the
// read-modify-write on the one-read, one-write table and registers the
// result, which shows for one cycle while busy is already low.
// After reset a clearing pass writes zero through the table with busy held
// high; configuration writes are taken throughout.
// The receiver cannot stall results, so nothing ever backs up.
module version_vector_merge #(
  parameter int NODE_COUNT = 64,
  parameter int SEQ_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [5:0]  node_index_i,
  input  logic        use_own_node_i,
  input  logic [31:0] entry_seq_i,
  input  logic        last_entry_i,
  // result
  output logic        result_valid_o,
  output logic        missing_valid_o,
  output logic [5:0]  missing_node_o,
  output logic [31:0] first_missing_o,
  output logic [31:0] last_missing_o,
  output logic        vector_done_o,
  output logic        local_has_newer_o,
  output logic        remote_had_newer_o,
  output logic        announce_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_own_node_i
);

  vvm_pkg::vvm_cmd_t  cmd;
  vvm_pkg::vvm_stat_t stat;

  // Own node register always takes writes
  assign cfg_ready_o = 1'b1;

  // Sequencer: sweep, idle, execute
  vvm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // Table, counters and result registers
  vvm_dpath #(
    .NODE_COUNT (NODE_COUNT),
    .SEQ_BITS   (SEQ_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_own_node_i     (cfg_own_node_i),
    .kind_i             (kind_i),
    .node_index_i       (node_index_i),
    .use_own_node_i     (use_own_node_i),
    .entry_seq_i        (entry_seq_i),
    .last_entry_i       (last_entry_i),
    .result_valid_o     (result_valid_o),
    .missing_valid_o    (missing_valid_o),
    .missing_node_o     (missing_node_o),
    .first_missing_o    (first_missing_o),
    .last_missing_o     (last_missing_o),
    .vector_done_o      (vector_done_o),
    .local_has_newer_o  (local_has_newer_o),
    .remote_had_newer_o (remote_had_newer_o),
    .announce_o         (announce_o)
  );

  // An accepted request holds busy for its execute cycle, with no result yet
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("request accepted but busy not held");

  // A result only follows an execute cycle and frees the block
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) && !busy))
    else $error("result without a preceding execute cycle");

  // Merge reports and local-update announce never share a result
  a_kind_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(announce_o && (missing_valid_o || vector_done_o)))
    else $error("merge and update fields mixed in one result");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the version vector merge block.
// Sends merge entries and local updates through the start/busy request port,
// predicts each result with a behavioural copy of the block's state, or takes a
// hand-written one, and compares each strobed result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES      = 64;
  localparam int ITEMS      = 750;
  localparam int PHASES     = 6;
  localparam int LIMIT      = 200000;
  localparam int REPORT_MAX = 10;

  // One request as the port sees it
  typedef struct packed {
    logic        kind;
    logic [5:0]  node;
    logic        use_own;
    logic [31:0] seq;
    logic        last;
  } vvm_req_t;

  // One result, in port order
  typedef struct packed {
    logic        missing_valid;
    logic [5:0]  missing_node;
    logic [31:0] first_missing;
    logic [31:0] last_missing;
    logic        vector_done;
    logic        local_has_newer;
    logic        remote_had_newer;
    logic        announce;
  } vvm_result_t;

  // Directed row: the request, plus a hand-written result where one is given
  typedef struct packed {
    vvm_req_t    req;
    logic        typed;
    vvm_result_t outcome;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        kind_i;
  logic [5:0]  node_index_i;
  logic        use_own_node_i;
  logic [31:0] entry_seq_i;
  logic        last_entry_i;
  logic        result_valid_o;
  logic        missing_valid_o;
  logic [5:0]  missing_node_o;
  logic [31:0] first_missing_o;
  logic [31:0] last_missing_o;
  logic        vector_done_o;
  logic        local_has_newer_o;
  logic        remote_had_newer_o;
  logic        announce_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [5:0]  cfg_own_node_i;

  version_vector_merge DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .node_index_i       (node_index_i),
    .use_own_node_i     (use_own_node_i),
    .entry_seq_i        (entry_seq_i),
    .last_entry_i       (last_entry_i),
    .result_valid_o     (result_valid_o),
    .missing_valid_o    (missing_valid_o),
    .missing_node_o     (missing_node_o),
    .first_missing_o    (first_missing_o),
    .last_missing_o     (last_missing_o),
    .vector_done_o      (vector_done_o),
    .local_has_newer_o  (local_has_newer_o),
    .remote_had_newer_o (remote_had_newer_o),
    .announce_o         (announce_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_own_node_i     (cfg_own_node_i)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  // Shadow of the block: local vector, counts and the open vector's flags
  logic [31:0] loc_seq [NODES];
  int          live_nodes;        // nonzero entries in the local vector
  int          named_live;        // named entries of the open vector, nonzero
  logic        saw_local_ahead;
  logic        saw_remote_ahead;
  logic [5:0]  own_idx;

  vvm_result_t pending_outcomes [$];
  stim_row_t   directed_rows [$];

  // Sideband from the driver: hand-written result for the request on the port
  logic        req_typed;
  vvm_result_t req_outcome;

  int gap_pct;
  int mismatches;
  int cycle_count;
  int merges_taken;
  int updates_taken;
  int vectors_closed;
  int gaps_reported;
  int announcements;
  int cfg_writes;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stop a hung run; the limit is far above the slowest correct run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, pending_outcomes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: apply one request to the shadow state, return its result
  // --------------------------------------------------------------------------
  function automatic vvm_result_t apply_request(input vvm_req_t r);
    vvm_result_t res;
    logic [5:0]  slot;
    logic [31:0] held;
    res = '0;
    if (r.kind == vvm_pkg::KIND_UPDATE) begin
      // Local update touches the table and the live count only
      slot = r.use_own ? own_idx : r.node;
      held = loc_seq[slot];
      if (held == 0 && r.seq != 0)
        live_nodes++;
      else if (held != 0 && r.seq == 0 && live_nodes > 0)
        live_nodes--;
      loc_seq[slot] = r.seq;
      res.announce  = (r.seq > held);
      return res;
    end
    held = loc_seq[r.node];
    if (held < r.seq) begin
      // Remote is ahead: report the gap and raise the local entry
      saw_remote_ahead  = 1'b1;
      res.missing_valid = 1'b1;
      res.missing_node  = r.node;
      res.first_missing = held + 32'd1;
      res.last_missing  = r.seq;
      if (held == 0)
        live_nodes++;
      loc_seq[r.node] = r.seq;
      held = r.seq;
    end else if (held > r.seq) begin
      saw_local_ahead = 1'b1;
    end
    // Saturate so a vector repeating nodes cannot run the count past the table
    if (held != 0 && named_live < NODES)
      named_live++;
    if (r.last) begin
      res.vector_done      = 1'b1;
      res.local_has_newer  = saw_local_ahead || (live_nodes > named_live);
      res.remote_had_newer = saw_remote_ahead;
      saw_local_ahead  = 1'b0;
      saw_remote_ahead = 1'b0;
      named_live       = 0;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge, check results before logging new ones
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] %s: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    vvm_req_t    seen;
    vvm_result_t want;
    if (rst_ni) begin
      // Results first: they belong to requests logged on earlier edges
      if (result_valid_o) begin
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] result strobed with nothing outstanding", $realtime);
        end else begin
          want = pending_outcomes.pop_front();
          check_field("missing_valid", 32'(missing_valid_o), 32'(want.missing_valid));
          check_field("missing_node", 32'(missing_node_o), 32'(want.missing_node));
          check_field("first_missing",    first_missing_o,    want.first_missing);
          check_field("last_missing",     last_missing_o,     want.last_missing);
          check_field("vector_done", 32'(vector_done_o), 32'(want.vector_done));
          check_field("local_has_newer", 32'(local_has_newer_o),
                      32'(want.local_has_newer));
          check_field("remote_had_newer", 32'(remote_had_newer_o),
                      32'(want.remote_had_newer));
          check_field("announce", 32'(announce_o), 32'(want.announce));
        end
      end
      if (start && !busy) begin
        seen = {kind_i, node_index_i, use_own_node_i, entry_seq_i, last_entry_i};
        want = apply_request(seen);
        // Hand-written rows override the predictor, which still advances
        if (req_typed)
          want = req_outcome;
        pending_outcomes.insert(pending_outcomes.size(), want);
        if (seen.kind == vvm_pkg::KIND_UPDATE)
          updates_taken++;
        else
          merges_taken++;
        if (want.vector_done)   vectors_closed++;
        if (want.missing_valid) gaps_reported++;
        if (want.announce)      announcements++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        own_idx = cfg_own_node_i;
        cfg_writes++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: everything changes on the falling edge
  // --------------------------------------------------------------------------
  // Hold the request until it is taken; return on the following falling edge
  task automatic send_request(input vvm_req_t r, input logic typed,
                              input vvm_result_t outcome);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    start          <= 1'b1;
    kind_i         <= r.kind;
    node_index_i   <= r.node;
    use_own_node_i <= r.use_own;
    entry_seq_i    <= r.seq;
    last_entry_i   <= r.last;
    req_typed      <= typed;
    req_outcome    <= outcome;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Drop start and wait for every outstanding result
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_own_node(input logic [5:0] v);
    cfg_valid_i    <= 1'b1;
    cfg_own_node_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input logic kind, input logic [5:0] node,
                         input logic use_own, input logic [31:0] seq,
                         input logic last, input logic typed,
                         input vvm_result_t outcome);
    stim_row_t row;
    row = {kind, node, use_own, seq, last, typed, outcome};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------
  // Bias sequences towards the interesting relations with the local value
  function automatic logic [31:0] seq_near(input logic [31:0] cur);
    case ($urandom_range(9, 0))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return cur;
      4, 5:    return cur + $urandom_range(16, 1);
      6:       return cur - $urandom_range(16, 1);
      default: return $urandom;
    endcase
  endfunction

  // Local update with noise on the last flag, which an update ignores
  function automatic vvm_req_t random_update();
    vvm_req_t r;
    r.kind    = vvm_pkg::KIND_UPDATE;
    r.node    = 6'($urandom);
    r.use_own = 1'($urandom_range(1, 0));
    r.last    = 1'($urandom_range(1, 0));
    r.seq     = seq_near(loc_seq[r.use_own ? own_idx : r.node]);
    return r;
  endfunction

  // Mostly whole vectors with random content; some updates alone or mid-vector,
  // some repeated nodes, now and then a full sync or an oversized vector
  task automatic random_traffic(input int count);
    vvm_req_t   r;
    logic [5:0] members [$];
    logic [5:0] base;
    logic [5:0] stride;
    int         mode;
    int         len;
    while (count > 0) begin
      mode = $urandom_range(99, 0);
      members.delete();
      if (mode < 15) begin
        send_request(random_update(), 1'b0, '0);
        count--;
      end else begin
        if (mode < 25) begin
          // Name every live node, so the local side may hold nothing newer
          for (int n = 0; n < NODES; n++)
            if (loc_seq[n] != 0) members.insert(members.size(), n[5:0]);
          if (members.size() == 0) members.insert(0, 6'($urandom));
        end else if (mode == 25) begin
          // Oversized vector: repeats push the named count towards its ceiling
          len = $urandom_range(80, 65);
          repeat (len) members.insert(members.size(), 6'($urandom));
        end else begin
          len    = $urandom_range(8, 1);
          base   = 6'($urandom);
          stride = {5'($urandom_range(31, 0)), 1'b1};
          for (int k = 0; k < len; k++)
            members.insert(members.size(),
                           ($urandom_range(9, 0) == 0) ? 6'($urandom)
                                                       : 6'(base + k * stride));
        end
        foreach (members[k]) begin
          if ($urandom_range(19, 0) == 0) begin
            send_request(random_update(), 1'b0, '0);
            count--;
          end
          r.kind    = vvm_pkg::KIND_MERGE;
          r.node    = members[k];
          r.use_own = 1'($urandom_range(1, 0));
          r.seq     = seq_near(loc_seq[members[k]]);
          r.last    = (k == members.size() - 1);
          send_request(r, 1'b0, '0);
          count--;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_gap [PHASES];
    logic [5:0] own_val;

    phase_gap = '{0, 48, 8, 0, 48, 8};

    for (int n = 0; n < NODES; n++) loc_seq[n] = '0;
    live_nodes       = 0;
    named_live       = 0;
    saw_local_ahead  = 1'b0;
    saw_remote_ahead = 1'b0;
    own_idx          = '0;
    mismatches       = 0;
    cycle_count      = 0;
    merges_taken     = 0;
    updates_taken    = 0;
    vectors_closed   = 0;
    gaps_reported    = 0;
    announcements    = 0;
    cfg_writes       = 0;
    gap_pct          = 0;

    rst_ni         = 1'b0;
    start          = 1'b0;
    kind_i         = vvm_pkg::KIND_MERGE;
    node_index_i   = '0;
    use_own_node_i = 1'b0;
    entry_seq_i    = '0;
    last_entry_i   = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_own_node_i = '0;
    req_typed      = 1'b0;
    req_outcome    = '0;

    // Directed rows, written for own node 63 from an empty vector.
    // The first six carry their result; the rest go to the predictor.
    //      kind                  node   own   seq            last  typed  result
    // empty vector closing on an unknown node: done, no verdicts
    add_row(vvm_pkg::KIND_MERGE,  6'd0,  1'b0, 32'h0000_0000, 1'b0 | 1'b1, 1'b1,
            {1'b0, 6'd0,  32'd0, 32'd0,         1'b1, 1'b0, 1'b0, 1'b0});
    // top node jumps to the largest sequence: gap 1 .. all ones
    add_row(vvm_pkg::KIND_MERGE,  6'd63, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1,
            {1'b1, 6'd63, 32'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0});
    // close with node 0 raised to 1: remote newer, local not
    add_row(vvm_pkg::KIND_MERGE,  6'd0,  1'b0, 32'h0000_0001, 1'b1, 1'b1,
            {1'b1, 6'd0,  32'd1, 32'd1,         1'b1, 1'b0, 1'b1, 1'b0});
    // own-node update at the same value: no rise (last flag ignored)
    add_row(vvm_pkg::KIND_UPDATE, 6'd0,  1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, '0);
    // named update clearing node 63 back to absent: no rise
    add_row(vvm_pkg::KIND_UPDATE, 6'd63, 1'b0, 32'h0000_0000, 1'b0, 1'b1, '0);
    // own-node update from absent to 7: announce
    add_row(vvm_pkg::KIND_UPDATE, 6'd5,  1'b1, 32'h0000_0007, 1'b0, 1'b1,
            {1'b0, 6'd0,  32'd0, 32'd0,         1'b0, 1'b0, 1'b0, 1'b1});
    // remote behind on one node, equal on another
    add_row(vvm_pkg::KIND_MERGE,  6'd63, 1'b0, 32'h0000_0003, 1'b0, 1'b0, '0);
    add_row(vvm_pkg::KIND_MERGE,  6'd0,  1'b0, 32'h0000_0001, 1'b1, 1'b0, '0);
    // same node twice in one vector; unnamed live nodes leave local newer
    add_row(vvm_pkg::KIND_MERGE,  6'd10, 1'b1, 32'h0000_0014, 1'b0, 1'b0, '0);
    add_row(vvm_pkg::KIND_MERGE,  6'd10, 1'b0, 32'h0000_0019, 1'b1, 1'b0, '0);
    // local update inside an open vector, then name every live node
    add_row(vvm_pkg::KIND_MERGE,  6'd0,  1'b0, 32'h0000_0001, 1'b0, 1'b0, '0);
    add_row(vvm_pkg::KIND_UPDATE, 6'd40, 1'b0, 32'h0000_0009, 1'b0, 1'b0, '0);
    add_row(vvm_pkg::KIND_MERGE,  6'd40, 1'b0, 32'h0000_0009, 1'b0, 1'b0, '0);
    add_row(vvm_pkg::KIND_MERGE,  6'd63, 1'b0, 32'h0000_0007, 1'b0, 1'b0, '0);
    add_row(vvm_pkg::KIND_MERGE,  6'd10, 1'b0, 32'h0000_0019, 1'b1, 1'b0, '0);
    // wide values and alternating bit patterns
    add_row(vvm_pkg::KIND_UPDATE, 6'd10, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    add_row(vvm_pkg::KIND_MERGE,  6'd1,  1'b0, 32'h8000_0000, 1'b1, 1'b0, '0);
    add_row(vvm_pkg::KIND_UPDATE, 6'd33, 1'b0, 32'hAAAA_AAAA, 1'b0, 1'b0, '0);
    add_row(vvm_pkg::KIND_MERGE,  6'd33, 1'b0, 32'h5555_5555, 1'b1, 1'b0, '0);

    // Hold reset, then release it on a falling edge
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      // Reconfigure only with nothing in flight
      if (p > 0)
        wait_idle();
      own_val = (p == 0) ? 6'd63 : (p == 1) ? 6'd0 : 6'($urandom);
      write_own_node(own_val);
      gap_pct = phase_gap[p];
      if (p == 0)
        foreach (directed_rows[i])
          send_request(directed_rows[i].req, directed_rows[i].typed,
                       directed_rows[i].outcome);
      random_traffic(ITEMS / PHASES);
    end

    // Drain, then allow the pipeline to settle
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d merge entries and %0d local updates over %0d own-node settings",
             merges_taken, updates_taken, cfg_writes);
    $display("%0d vectors closed, %0d gaps reported, %0d announcements, %0d cycles",
             vectors_closed, gaps_reported, announcements, cycle_count);
    if (mismatches == 0 && pending_outcomes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
